>>> design/bdrq_pkg.sv
// bdrq_pkg: shared constants and types for the banded deadline run queue
// no dependencies

package bdrq_pkg;

  localparam int NUM_SLOTS_DEF     = 16;
  localparam int NUM_BANDS_DEF     = 3;
  localparam int DEADLINE_BITS_DEF = 32;
  localparam int BAND_CODES        = 4;

  typedef enum logic [1:0] {
    MODE_READY  = 2'd0,
    MODE_YIELD  = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_BAND    = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_IS_CURRENT  = 3'd3,
    ST_NOTHING     = 3'd4,
    ST_NOT_QUEUED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_SCAN,
    S_YIELD,
    S_DONE
  } fsm_t;

  localparam logic REG_BOOT_THREAD = 1'b0;
  localparam logic REG_BOOT_BAND   = 1'b1;

endpackage

>>> design/bdrq_ram.sv
// bdrq_ram: generic single write, single read ram with registered read
// no dependencies

module bdrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/banded_deadline_run_queue.sv
// banded_deadline_run_queue: run queue with priority bands ordered by deadline
// depends on bdrq_pkg and bdrq_ram
//
//  channel | dir | handshake          | word
//  s       | in  | s_tvalid/s_tready  | mode, thread_id, band, deadline
//  m       | out | m_tvalid/m_tready  | status .. band_queued
//  cfg     | in  | cfg_we             | boot_thread, boot_band
//
// ready and query go straight to the done step, remove passes a remove step first;
// yield sweeps the slot ram, one entry per cycle, to find the head
// reset is synchronous; no clearing pass, valid bits sit in flops
// an input word is taken while a finished result waits on m; a stall on m
// holds the block at its last step until the result register frees

module banded_deadline_run_queue
  import bdrq_pkg::*;
#(
  parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
  parameter int NUM_BANDS     = NUM_BANDS_DEF,
  parameter int DEADLINE_BITS = DEADLINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode, thread_id, band, deadline
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status, switched, running_thread, assigned_deadline,
                                 // total_queued, band_queued
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int RW = $clog2(NUM_SLOTS + 1);
  localparam int DW = DEADLINE_BITS;
  localparam logic [DW-1:0] DL_MAX = {DW{1'b1}};
  localparam logic [1:0] LAST_BAND = 2'(NUM_BANDS - 1);

  logic [1:0]  in_mode;
  logic [3:0]  in_tid;
  logic [1:0]  in_band;
  logic [31:0] in_dl;
  assign in_mode = s_tdata[1:0];
  assign in_tid  = s_tdata[5:2];
  assign in_band = s_tdata[7:6];
  assign in_dl   = s_tdata[39:8];

  fsm_t state, state_next;

  logic [NUM_SLOTS-1:0] queued, queued_next;
  logic [RW-1:0] rank [NUM_SLOTS];
  logic [RW-1:0] rank_next [NUM_SLOTS];
  logic [RW-1:0] ocnt, ocnt_next;
  logic [RW-1:0] bcnt [BAND_CODES];
  logic [RW-1:0] bcnt_next [BAND_CODES];

  logic [DW-1:0] dcnt;
  logic [3:0]    cur;
  logic [1:0]    cur_band;
  logic          cfg_pend;

  logic [3:0]    i_tid;
  logic [1:0]    i_band;
  status_t       r_status;
  logic          r_switched;
  logic [DW-1:0] r_assigned;

  logic [SW:0]   scan_cnt;
  logic [SW-1:0] cmp_idx;
  logic          cmp_vld;
  logic          best_v;
  logic [SW-1:0] best_slot;
  logic [1:0]    best_band;
  logic [DW-1:0] best_dl;
  logic [RW-1:0] best_rank;

  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [DW+1:0] ram_wdata, ram_rdata;
  logic [1:0]    rd_band;
  logic [DW-1:0] rd_dl;
  assign rd_band = ram_rdata[DW+1:DW];
  assign rd_dl   = ram_rdata[DW-1:0];

  bdrq_ram #(.WIDTH(DW + 2), .DEPTH(NUM_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic          deq_en, enq_en, bdec_en, binc_en;
  logic [SW-1:0] deq_slot, enq_slot;
  logic [1:0]    bdec_band, binc_band;

  logic [SW-1:0] in_idx, i_idx, cur_idx, cfg_idx;
  logic          in_ok, cur_ok, cfg_ok;
  assign in_idx  = SW'(in_tid);
  assign i_idx   = SW'(i_tid);
  assign cur_idx = SW'(cur);
  assign cfg_idx = SW'(cfg_data);
  assign in_ok   = 32'(in_tid) < NUM_SLOTS;
  assign cur_ok  = 32'(cur) < NUM_SLOTS;
  assign cfg_ok  = 32'(cfg_data) < NUM_SLOTS;

  logic accept, cfg_thread_wr, cand_better;
  logic [1:0] prev_band;
  assign s_tready = (state == S_IDLE) && !cfg_pend;
  assign accept   = s_tvalid && s_tready;
  assign cfg_thread_wr = cfg_we && (cfg_index == REG_BOOT_THREAD);
  assign prev_band = (32'(cur_band) < NUM_BANDS) ? cur_band : LAST_BAND;

  assign cand_better = !best_v || (rd_band < best_band) ||
                       ((rd_band == best_band) && ((rd_dl < best_dl) ||
                        ((rd_dl == best_dl) && (rank[cmp_idx] < best_rank))));

  // control
  always_comb begin
    state_next = state;
    deq_en = 1'b0; deq_slot = '0;
    enq_en = 1'b0; enq_slot = '0;
    bdec_en = 1'b0; bdec_band = rd_band;
    binc_en = 1'b0; binc_band = in_band;
    ram_we = 1'b0; ram_waddr = in_idx; ram_wdata = {in_band, DW'(in_dl)};
    ram_raddr = in_idx;
    if (cfg_pend) begin
      bdec_en = 1'b1;
    end
    unique case (state)
      S_IDLE: begin
        if (cfg_thread_wr) begin
          ram_raddr = cfg_idx;
          if (cfg_ok && queued[cfg_idx]) begin
            deq_en = 1'b1;
            deq_slot = cfg_idx;
          end
        end else if (accept) begin
          unique case (in_mode)
            MODE_READY: begin
              state_next = S_DONE;
              if (in_tid != cur && 32'(in_band) < NUM_BANDS && in_ok && !queued[in_idx]) begin
                enq_en = 1'b1;
                enq_slot = in_idx;
                binc_en = 1'b1;
                ram_we = 1'b1;
              end
            end
            MODE_YIELD: state_next = S_SCAN;
            MODE_REMOVE: state_next = (in_ok && queued[in_idx]) ? S_REMOVE : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_REMOVE: begin
        deq_en = 1'b1;
        deq_slot = i_idx;
        bdec_en = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        ram_raddr = scan_cnt[SW-1:0];
        if (cmp_vld && 32'(cmp_idx) == NUM_SLOTS - 1) begin
          state_next = S_YIELD;
        end
      end
      S_YIELD: begin
        state_next = S_DONE;
        if (best_v) begin
          deq_en = 1'b1;
          deq_slot = best_slot;
          bdec_en = 1'b1;
          bdec_band = best_band;
          if (cur_ok && !queued[cur_idx]) begin
            enq_en = 1'b1;
            enq_slot = cur_idx;
            binc_en = 1'b1;
            binc_band = prev_band;
            ram_we = 1'b1;
            ram_waddr = cur_idx;
            ram_wdata = {prev_band, dcnt};
          end
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // queue bookkeeping
  always_comb begin
    queued_next = queued;
    rank_next = rank;
    ocnt_next = ocnt;
    bcnt_next = bcnt;
    if (deq_en) begin
      queued_next[deq_slot] = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (queued[i] && rank[i] > rank[deq_slot]) begin
          rank_next[i] = rank[i] - 1'b1;
        end
      end
      ocnt_next = ocnt - 1'b1;
    end
    if (enq_en) begin
      queued_next[enq_slot] = 1'b1;
      rank_next[enq_slot] = ocnt_next;
      ocnt_next = ocnt_next + 1'b1;
    end
    if (bdec_en) begin
      bcnt_next[bdec_band] = bcnt_next[bdec_band] - 1'b1;
    end
    if (binc_en) begin
      bcnt_next[binc_band] = bcnt_next[binc_band] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      queued <= '0;
      ocnt <= '0;
      for (int b = 0; b < BAND_CODES; b++) begin
        bcnt[b] <= '0;
      end
      dcnt <= DW'(1);
      cur <= 4'd0;
      cur_band <= 2'd1;
      cfg_pend <= 1'b0;
      m_tvalid <= 1'b0;
      cmp_vld <= 1'b0;
      best_v <= 1'b0;
    end else begin
      state <= state_next;
      queued <= queued_next;
      ocnt <= ocnt_next;
      bcnt <= bcnt_next;
      cfg_pend <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_BOOT_THREAD) begin
          cur <= cfg_data;
          cfg_pend <= cfg_ok && queued[cfg_idx];
        end else begin
          cur_band <= cfg_data[1:0];
        end
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          best_v <= 1'b0;
        end
        S_SCAN: begin
          cmp_vld <= 32'(scan_cnt) < NUM_SLOTS;
          if (cmp_vld && queued[cmp_idx] && cand_better) begin
            best_v <= 1'b1;
          end
        end
        S_YIELD: begin
          if (best_v) begin
            cur <= 4'(best_slot);
            cur_band <= best_band;
            if (dcnt != DL_MAX) begin
              dcnt <= dcnt + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rank <= rank_next;
    if (accept) begin
      i_tid <= in_tid;
      i_band <= in_band;
      r_switched <= 1'b0;
      r_assigned <= '0;
      scan_cnt <= '0;
      if (in_mode == MODE_READY) begin
        if (in_tid == cur) begin
          r_status <= ST_IS_CURRENT;
        end else if (32'(in_band) >= NUM_BANDS || !in_ok) begin
          r_status <= ST_BAD_BAND;
        end else if (queued[in_idx]) begin
          r_status <= ST_QUEUED;
        end else begin
          r_status <= ST_OK;
        end
      end else if (in_mode == MODE_REMOVE && !(in_ok && queued[in_idx])) begin
        r_status <= ST_NOT_QUEUED;
      end else begin
        r_status <= ST_OK;
      end
    end
    if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
      cmp_idx <= scan_cnt[SW-1:0];
      if (cmp_vld && queued[cmp_idx] && cand_better) begin
        best_slot <= cmp_idx;
        best_band <= rd_band;
        best_dl <= rd_dl;
        best_rank <= rank[cmp_idx];
      end
    end
    if (state == S_YIELD) begin
      if (best_v) begin
        r_switched <= 1'b1;
        r_assigned <= dcnt;
      end else begin
        r_status <= ST_NOTHING;
      end
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata[2:0] <= r_status;
      m_tdata[3] <= r_switched;
      m_tdata[7:4] <= cur;
      m_tdata[39:8] <= 32'(r_assigned);
      m_tdata[44:40] <= 5'(ocnt);
      m_tdata[49:45] <= (32'(i_band) < NUM_BANDS) ? 5'(bcnt[i_band]) : 5'd0;
      m_tdata[55:50] <= 6'd0;
    end
  end

endmodule
